>>> design/first_fit_allocator_coalescing_unit_assert.svh
// Assertion macros used by the port checker.
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_UNIT_ASSERT_SVH
// Check that a condition implies another on the same edge.
`define FFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies another on the next edge.
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and codes shared by the first-fit allocator modules.
// ----------------------------------------------------------------------------
package ffa_pkg;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// table cell commands
	localparam logic [1:0] CMD_HOLD  = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_RIGHT = 2'd2;
	localparam logic [1:0] CMD_LEFT  = 2'd3;

	// pool size after reset
	localparam logic [15:0] POOL_RESET = 16'hFFFF;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_size;
		logic [15:0] free_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] granted_address;
		logic [4:0]  free_segments;
		logic [15:0] allocated_total;
		logic [31:0] nodes_searched;
	} rsp_t;
endpackage

>>> design/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One slot of a segment table: holds (start, length) and shifts toward
// either neighbor, or loads new contents, under a common command.
// ----------------------------------------------------------------------------
module ffa_cell
	import ffa_pkg::*;
#(
	parameter int            AW        = 16,
	parameter logic [AW-1:0] RST_START = '0,
	parameter logic [AW-1:0] RST_LEN   = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    cmd,
	input  logic [AW-1:0] ld_start,
	input  logic [AW-1:0] ld_len,
	input  logic [AW-1:0] r_start,
	input  logic [AW-1:0] r_len,
	input  logic [AW-1:0] l_start,
	input  logic [AW-1:0] l_len,
	output logic [AW-1:0] start,
	output logic [AW-1:0] len
);
	logic [AW-1:0] start_q, len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RST_START;
			len_q   <= RST_LEN;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					start_q <= ld_start;
					len_q   <= ld_len;
				end
				CMD_RIGHT: begin
					start_q <= r_start;
					len_q   <= r_len;
				end
				CMD_LEFT: begin
					start_q <= l_start;
					len_q   <= l_len;
				end
				default: begin
					start_q <= start_q;
					len_q   <= len_q;
				end
			endcase
		end
	end

	assign start = start_q;
	assign len   = len_q;
endmodule

>>> design/first_fit_allocator_coalescing_unit.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit
// First-fit allocator over one pool with a coalescing free-segment table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| req_t
//  rsp     | out       | rsp_valid/rsp_stall| rsp_t
//  cfg     | in        | cfg_valid/cfg_ready| pool_size
//
// Both tables are rows of cells: scans step a cursor one entry a cycle, edits
// shift a run of cells toward a neighbor together. An alloc scans the free
// table for the first fit, then edits both tables; a free scans the used
// table for its address, removes that entry, scans the free table for the
// insert position, then inserts or merges below and merges above. One
// request in flight; the next is taken on the edge that drains the result,
// and cfg_valid holds the input off. Reset leaves one free segment spanning
// 65535; a config write re-initializes the pool but keeps the search counter.
module first_fit_allocator_coalescing_unit
	import ffa_pkg::*;
#(
	parameter int MAX_ALLOCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] pool_size
);
	localparam int FD = MAX_ALLOCS + 1;
	localparam int FW = $clog2(FD + 1);
	localparam int UW = $clog2(MAX_ALLOCS + 1);
	localparam int AW = 16;

	typedef enum logic [3:0] {
		S_IDLE, S_ASCAN, S_AEDIT, S_USCAN, S_UREM, S_FSCAN, S_FINS, S_FMRG,
		S_DONE
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [FW-1:0] fcnt_q, pos_q;
	logic [UW-1:0] ucnt_q, upos_q;
	logic [AW-1:0] live_q, len_q;
	logic [31:0]   srch_q;
	logic          out_v_q;
	rsp_t          out_q;

	// free table
	logic [1:0]    fcmd [FD];
	logic [AW-1:0] fst [FD], fln [FD];
	logic [AW-1:0] fld_s [FD], fld_l [FD];
	// used table
	logic [1:0]    ucmd [MAX_ALLOCS];
	logic [AW-1:0] ust [MAX_ALLOCS], uln [MAX_ALLOCS];

	genvar g;
	generate
		for (g = 0; g < FD; g++) begin : g_free
			// reset leaves the whole pool in the first free slot
			ffa_cell #(.AW(AW), .RST_LEN((g == 0) ? POOL_RESET : '0)) u_cell (
				.clk, .arst_n, .cmd(fcmd[g]),
				.ld_start(fld_s[g]), .ld_len(fld_l[g]),
				.r_start(g + 1 < FD ? fst[(g + 1) % FD] : '0),
				.r_len(g + 1 < FD ? fln[(g + 1) % FD] : '0),
				.l_start(g > 0 ? fst[(g + FD - 1) % FD] : '0),
				.l_len(g > 0 ? fln[(g + FD - 1) % FD] : '0),
				.start(fst[g]), .len(fln[g])
			);
		end
		for (g = 0; g < MAX_ALLOCS; g++) begin : g_used
			ffa_cell #(.AW(AW)) u_cell (
				.clk, .arst_n, .cmd(ucmd[g]),
				.ld_start(req_q.opcode == OP_ALLOC ? fst[pos_q[$clog2(FD)-1:0]] : '0),
				.ld_len(req_q.request_size),
				.r_start(g + 1 < MAX_ALLOCS ? ust[(g + 1) % MAX_ALLOCS] : '0),
				.r_len(g + 1 < MAX_ALLOCS ? uln[(g + 1) % MAX_ALLOCS] : '0),
				.l_start('0), .l_len('0),
				.start(ust[g]), .len(uln[g])
			);
		end
	endgenerate

	// Cursor views.
	logic [$clog2(FD)-1:0] pi, pim1;
	logic [AW-1:0] cur_s, cur_l, prv_s, prv_l, nxt_s;
	logic [AW:0]   prv_end, cur_end;
	assign pi   = pos_q[$clog2(FD)-1:0];
	assign pim1 = pi - 1'b1;
	assign cur_s = fst[pi];
	assign cur_l = fln[pi];
	assign prv_s = fst[pim1];
	assign prv_l = fln[pim1];
	assign nxt_s = fst[(pi == $clog2(FD)'(FD - 1)) ? pi : pi + 1'b1];
	assign prv_end = {1'b0, prv_s} + {1'b0, prv_l};
	assign cur_end = {1'b0, cur_s} + {1'b0, cur_l};

	logic start_ok;
	assign start_ok  = (state_q == S_IDLE) && (!out_v_q || !rsp_stall) && !cfg_valid;
	assign req_stall = !start_ok;
	assign cfg_ready = (state_q == S_IDLE);
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// Cell commands.
	always_comb begin
		for (int i = 0; i < FD; i++) begin
			fcmd[i]  = CMD_HOLD;
			fld_s[i] = cur_s;
			fld_l[i] = cur_l;
		end
		for (int i = 0; i < MAX_ALLOCS; i++) ucmd[i] = CMD_HOLD;
		if (cfg_valid && cfg_ready) begin
			fcmd[0]  = CMD_LOAD;
			fld_s[0] = '0;
			fld_l[0] = pool_size;
		end
		case (state_q)
			S_AEDIT: begin
				ucmd[ucnt_q[$clog2(MAX_ALLOCS)-1:0]] = CMD_LOAD;
				if (cur_l == req_q.request_size) begin
					for (int i = 0; i < FD; i++)
						if (FW'(i) >= pos_q && FW'(i) + 1'b1 < fcnt_q) fcmd[i] = CMD_RIGHT;
				end else begin
					fcmd[pi]  = CMD_LOAD;
					fld_s[pi] = cur_s + req_q.request_size;
					fld_l[pi] = cur_l - req_q.request_size;
				end
			end
			S_UREM: begin
				for (int i = 0; i < MAX_ALLOCS; i++)
					if (UW'(i) >= upos_q && UW'(i) + 1'b1 < ucnt_q) ucmd[i] = CMD_RIGHT;
			end
			S_FINS: begin
				if (pos_q != '0 && prv_end == {1'b0, req_q.free_address}) begin
					fcmd[pim1]  = CMD_LOAD;
					fld_s[pim1] = prv_s;
					fld_l[pim1] = prv_l + len_q;
				end else begin
					for (int i = 0; i < FD; i++)
						if (FW'(i) > pos_q && FW'(i) <= fcnt_q) fcmd[i] = CMD_LEFT;
					fcmd[pi]  = CMD_LOAD;
					fld_s[pi] = req_q.free_address;
					fld_l[pi] = len_q;
				end
			end
			S_FMRG: begin
				if (pos_q + 1'b1 < fcnt_q && cur_end == {1'b0, nxt_s}) begin
					fcmd[pi]  = CMD_LOAD;
					fld_s[pi] = cur_s;
					fld_l[pi] = cur_l + fln[pi + 1'b1];
					for (int i = 0; i < FD; i++)
						if (FW'(i) > pos_q && FW'(i) + 1'b1 < fcnt_q) fcmd[i] = CMD_RIGHT;
				end
			end
			default: ;
		endcase
	end

	// Sequencer: one clocked block holds state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			fcnt_q  <= FW'(1);
			ucnt_q  <= '0;
			live_q  <= '0;
			len_q   <= '0;
			srch_q  <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
			pos_q   <= '0;
			upos_q  <= '0;
		end else begin
			if (out_v_q && !rsp_stall) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						fcnt_q <= (pool_size != '0) ? FW'(1) : '0;
						ucnt_q <= '0;
						live_q <= '0;
					end else if (req_valid && start_ok) begin
						req_q  <= req;
						pos_q  <= '0;
						upos_q <= '0;
						if (req.opcode == OP_ALLOC) begin
							if (req.request_size == '0) begin
								out_q   <= '{ST_ZERO, '0, 5'(fcnt_q), live_q, srch_q};
								state_q <= S_DONE;
							end else if (ucnt_q == UW'(MAX_ALLOCS)) begin
								out_q   <= '{ST_FULL, '0, 5'(fcnt_q), live_q, srch_q};
								state_q <= S_DONE;
							end else begin
								state_q <= S_ASCAN;
							end
						end else begin
							state_q <= S_USCAN;
						end
					end
				end
				S_ASCAN: begin
					if (pos_q >= fcnt_q) begin
						srch_q  <= srch_q + 1'b1;
						out_q   <= '{ST_NOFIT, '0, 5'(fcnt_q), live_q, srch_q + 1'b1};
						state_q <= S_DONE;
					end else begin
						srch_q <= srch_q + 1'b1;
						if (cur_l >= req_q.request_size) state_q <= S_AEDIT;
						else pos_q <= pos_q + 1'b1;
					end
				end
				S_AEDIT: begin
					ucnt_q <= ucnt_q + 1'b1;
					live_q <= live_q + req_q.request_size;
					if (cur_l == req_q.request_size) fcnt_q <= fcnt_q - 1'b1;
					out_q <= '{ST_OK, cur_s,
						5'((cur_l == req_q.request_size) ? fcnt_q - 1'b1 : fcnt_q),
						live_q + req_q.request_size, srch_q};
					state_q <= S_DONE;
				end
				S_USCAN: begin
					if (upos_q >= ucnt_q) begin
						out_q   <= '{ST_UNKNOWN, '0, 5'(fcnt_q), live_q, srch_q};
						state_q <= S_DONE;
					end else if (ust[upos_q[$clog2(MAX_ALLOCS)-1:0]] == req_q.free_address) begin
						len_q   <= uln[upos_q[$clog2(MAX_ALLOCS)-1:0]];
						state_q <= S_UREM;
					end else begin
						upos_q <= upos_q + 1'b1;
					end
				end
				S_UREM: begin
					ucnt_q  <= ucnt_q - 1'b1;
					live_q  <= live_q - len_q;
					srch_q  <= srch_q + 1'b1;
					state_q <= S_FSCAN;
				end
				S_FSCAN: begin
					if (pos_q < fcnt_q && cur_s < req_q.free_address) begin
						pos_q  <= pos_q + 1'b1;
						srch_q <= srch_q + 1'b1;
					end else begin
						state_q <= S_FINS;
					end
				end
				S_FINS: begin
					if (pos_q != '0 && prv_end == {1'b0, req_q.free_address}) begin
						pos_q <= pos_q - 1'b1;
					end else begin
						fcnt_q <= fcnt_q + 1'b1;
					end
					state_q <= S_FMRG;
				end
				S_FMRG: begin
					if (pos_q + 1'b1 < fcnt_q && cur_end == {1'b0, nxt_s}) begin
						fcnt_q <= fcnt_q - 1'b1;
						out_q  <= '{ST_OK, '0, 5'(fcnt_q - 1'b1), live_q, srch_q};
					end else begin
						out_q  <= '{ST_OK, '0, 5'(fcnt_q), live_q, srch_q};
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator's request and result channels.
// ----------------------------------------------------------------------------
`include "first_fit_allocator_coalescing_unit_assert.svh"
module ffa_checker
	import ffa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);
	`FFA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result dropped while stalled")
	`FFA_ASSERT_IMPL(a_status_range, clk, arst_n, rsp_valid, rsp.status <= ST_FULL, "status out of range")
	`FFA_ASSERT_IMPL(a_addr_zero, clk, arst_n, rsp_valid && rsp.status != ST_OK, rsp.granted_address == '0, "address on error")
	`FFA_ASSERT_NEXT(a_one_busy, clk, arst_n, req_valid && !req_stall, req_stall, "second request taken while busy")
endmodule

bind first_fit_allocator_coalescing_unit ffa_checker u_ffa_checker (
	.clk, .arst_n, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp
);

>>> tb/first_fit_allocator_coalescing_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit_checker
// Watches the request, result and pool-size channels of the allocator. Keeps
// its own first-fit pool model, queues the result it expects for each
// accepted request, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing_unit_checker
	import ffa_pkg::*;
#(
	parameter int MAX_ALLOCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] pool_size,
	output int          errors,
	output int          pending
);
	localparam int FDEPTH = MAX_ALLOCS + 1;

	logic [15:0] seg_start [FDEPTH];
	logic [15:0] seg_len [FDEPTH];
	int          seg_count;
	logic [15:0] blk_start [MAX_ALLOCS];
	logic [15:0] blk_len [MAX_ALLOCS];
	int          blk_count;
	logic [15:0] live_total;
	logic [31:0] scan_count;
	rsp_t        expected_rsp [$];

	assign pending = expected_rsp.size();

	function automatic void pool_init(input logic [15:0] size);
		seg_start[0] = '0;
		seg_len[0]   = size;
		seg_count    = (size != 0) ? 1 : 0;
		blk_count    = 0;
		live_total   = '0;
	endfunction

	function automatic void seg_drop(input int idx);
		for (int k = idx; k + 1 < seg_count; k++) begin
			seg_start[k] = seg_start[k + 1];
			seg_len[k]   = seg_len[k + 1];
		end
		if (seg_count > 0)
			seg_count--;
	endfunction

	function automatic rsp_t predict_alloc_result(input req_t r);
		rsp_t        o;
		int          i;
		int          u;
		int          pos;
		logic [15:0] len;
		logic [16:0] span;
		o = '0;
		if (r.opcode == OP_ALLOC) begin
			if (r.request_size == 0)
				o.status = ST_ZERO;
			else if (blk_count >= MAX_ALLOCS)
				o.status = ST_FULL;
			else begin
				for (i = 0; i < seg_count; i++) begin
					scan_count++;
					if (seg_len[i] >= r.request_size)
						break;
				end
				if (i >= seg_count) begin
					scan_count++;
					o.status = ST_NOFIT;
				end else begin
					o.status          = ST_OK;
					o.granted_address = seg_start[i];
					blk_start[blk_count] = seg_start[i];
					blk_len[blk_count]   = r.request_size;
					blk_count++;
					if (seg_len[i] == r.request_size)
						seg_drop(i);
					else begin
						seg_start[i] = seg_start[i] + r.request_size;
						seg_len[i]   = seg_len[i] - r.request_size;
					end
					live_total = live_total + r.request_size;
				end
			end
		end else begin
			for (u = 0; u < blk_count; u++)
				if (blk_start[u] == r.free_address)
					break;
			if (u >= blk_count)
				o.status = ST_UNKNOWN;
			else begin
				o.status = ST_OK;
				len = blk_len[u];
				for (int k = u; k + 1 < blk_count; k++) begin
					blk_start[k] = blk_start[k + 1];
					blk_len[k]   = blk_len[k + 1];
				end
				blk_count--;
				live_total = live_total - len;
				scan_count++;
				pos = 0;
				while (pos < seg_count && seg_start[pos] < r.free_address) begin
					pos++;
					scan_count++;
				end
				// merge with the lower neighbor if it ends at the released start
				span = (pos > 0) ? {1'b0, seg_start[pos - 1]} + seg_len[pos - 1] : '0;
				if (pos > 0 && span == {1'b0, r.free_address}) begin
					seg_len[pos - 1] = seg_len[pos - 1] + len;
					pos--;
				end else if (seg_count < FDEPTH) begin
					for (int k = seg_count; k > pos; k--) begin
						seg_start[k] = seg_start[k - 1];
						seg_len[k]   = seg_len[k - 1];
					end
					seg_start[pos] = r.free_address;
					seg_len[pos]   = len;
					seg_count++;
				end
				if (pos + 1 < seg_count &&
						{1'b0, seg_start[pos]} + seg_len[pos] == {1'b0, seg_start[pos + 1]}) begin
					seg_len[pos] = seg_len[pos] + seg_len[pos + 1];
					seg_drop(pos + 1);
				end
			end
		end
		o.free_segments   = seg_count[4:0];
		o.allocated_total = live_total;
		o.nodes_searched  = scan_count;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			errors     = 0;
			scan_count = '0;
			expected_rsp.delete();
			pool_init(16'hFFFF);
		end else begin
			if (cfg_valid && cfg_ready)
				pool_init(pool_size);
			if (req_valid && !req_stall)
				expected_rsp.push_back(predict_alloc_result(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.status !== e.status || rsp.granted_address !== e.granted_address ||
							rsp.free_segments !== e.free_segments ||
							rsp.allocated_total !== e.allocated_total ||
							rsp.nodes_searched !== e.nodes_searched) begin
						errors++;
						$display("%0t: result mismatch, expected %p, actual %p", $time, e, rsp);
					end
				end
			end
		end
	end
endmodule

>>> tb/first_fit_allocator_coalescing_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit_tb
// Drives allocate and free requests through the allocator under random
// bursts, gaps and result stalls, reconfigures the pool between phases, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing_unit_tb;
	import ffa_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] pool_size;
	int          errors;
	int          pending;
	bit          hold_off;

	// live allocations as the stimulus side believes them, for valid frees
	logic [15:0] granted_addr [$];

	first_fit_allocator_coalescing_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_size(pool_size)
	);

	first_fit_allocator_coalescing_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_size(pool_size),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Harvest granted addresses so later frees mostly hit live blocks.
	always @(posedge clk)
		if (rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.granted_address != 0)
			granted_addr.push_back(rsp.granted_address);

	// Stall the result side on its own pattern; a long hold-off fills the block.
	initial begin
		int mode;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off)
				rsp_stall <= 1'b1;
			else begin
				mode = $urandom_range(0, 9);
				rsp_stall <= (mode < 3) ? 1'b1 : 1'b0;
			end
		end
	end

	// Present one request and hold it until accepted.
	task automatic send_request(input logic op, input logic [15:0] size,
			input logic [15:0] addr);
		req_t r;
		r.opcode       = op;
		r.request_size = size;
		r.free_address = addr;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid for a random gap between bursts.
	task automatic idle_gap(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_and_settle();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_pool(input logic [15:0] size);
		pool_size <= size;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		granted_addr.delete();
	endtask

	// One random request: mostly sensible allocs and frees of live blocks.
	task automatic random_request(input logic [15:0] pool);
		int          pick;
		int          idx;
		logic [15:0] size;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			size = (pool < 16) ? 16'($urandom_range(1, 16))
				: 16'($urandom_range(1, pool / 8));
			send_request(OP_ALLOC, size, 16'($urandom));
		end else if (pick < 85 && granted_addr.size() > 0) begin
			idx = $urandom_range(0, granted_addr.size() - 1);
			size = granted_addr[idx];
			granted_addr.delete(idx);
			send_request(OP_FREE, 16'($urandom), size);
		end else if (pick < 88)
			send_request(OP_FREE, 16'($urandom), 16'h0000);
		else if (pick < 93)
			send_request(OP_ALLOC, 16'($urandom), 16'($urandom));
		else if (pick < 96)
			send_request(OP_ALLOC, 16'h0000, 16'($urandom));
		else
			send_request(OP_FREE, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		logic [15:0] pools [6];
		int          burst;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		pool_size = 16'hFFFF;
		hold_off  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, zero size, no fit, unknown address.
		send_request(OP_ALLOC, 16'h0000, 16'hFFFF);
		send_request(OP_ALLOC, 16'hFFFF, 16'h0000);
		send_request(OP_FREE, 16'h0000, 16'hFFFF);
		send_request(OP_FREE, 16'hFFFF, 16'h0000);
		send_request(OP_ALLOC, 16'hFFFF, 16'h0000);
		send_request(OP_ALLOC, 16'h0001, 16'h0000);
		for (int k = 0; k < 16; k++)
			send_request(OP_ALLOC, 16'h0010, 16'h0000);
		send_request(OP_ALLOC, 16'h0001, 16'h0000);
		send_request(OP_FREE, 16'h0000, 16'h0020);
		send_request(OP_FREE, 16'h0000, 16'h0010);
		send_request(OP_FREE, 16'h0000, 16'h0030);
		drain_and_settle();

		pools = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0040, 16'h1000, 16'h0300};
		for (int p = 0; p < 6; p++) begin
			write_pool(pools[p]);
			if (p == 0) begin
				send_request(OP_ALLOC, 16'h0001, 16'h0000);
				send_request(OP_FREE, 16'h0000, 16'h0000);
			end
			if (p == 1) begin
				send_request(OP_ALLOC, 16'h0001, 16'h0000);
				send_request(OP_FREE, 16'h0000, 16'h0000);
			end
			for (int n = 0; n < 230; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < 230; b++, n++)
					random_request(pools[p]);
				if ($urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 40));
				if (p == 2 && n >= 100 && n < 113) begin
					// starve the result side while requests keep coming
					fork
						begin
							hold_off = 1'b1;
							repeat (400) @(negedge clk);
							hold_off = 1'b0;
						end
						begin
							for (int q = 0; q < 6; q++)
								random_request(pools[p]);
						end
					join
				end
			end
			drain_and_settle();
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
